@@ hw/rtl/lfuc_pkg.sv @@
package lfuc_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int KEY_W         = 32;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 31;
    localparam int CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Register byte addresses.
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_TOUCH = 2'd1,
        CMD_FILL  = 2'd2
    } cell_kind_t;

    // Command broadcast from the controller to every cell in the row.
    typedef struct packed {
        cell_kind_t         kind;
        logic               is_put;
        logic               evict;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  value;
    } cell_cmd_t;

    // Contents of one cell as seen by the controller.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
    } cell_stat_t;

endpackage

@@ hw/rtl/lfuc_cell.sv @@
module lfuc_cell #(
    parameter int RANK_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfuc_pkg::cell_cmd_t  cmd,
    input  logic                 sel,
    input  logic [RANK_W-1:0]    ref_rank,
    input  logic [31:0]          lookup_key,
    output lfuc_pkg::cell_stat_t stat,
    output logic [RANK_W-1:0]    rank
);
    import lfuc_pkg::*;

    logic               valid_reg, valid_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        case (cmd.kind)
            CMD_TOUCH:
            begin
                if (sel)
                begin
                    if (count_reg != {COUNT_W{1'b1}})
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    rank_next = '0;
                    if (cmd.is_put)
                    begin
                        value_next = cmd.value;
                    end
                end
                else if (valid_reg && (rank_reg < ref_rank))
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            CMD_FILL:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    key_next   = cmd.key;
                    value_next = cmd.value;
                    count_next = COUNT_W'(1);
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    // Close the gap left by the evicted entry, then age by one.
                    if (cmd.evict && (rank_reg > ref_rank))
                    begin
                        rank_next = rank_reg;
                    end
                    else
                    begin
                        rank_next = rank_reg + RANK_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
    end

    assign stat.valid = valid_reg;
    assign stat.hit   = valid_reg && (key_reg == lookup_key);
    assign stat.value = value_reg;
    assign stat.count = count_reg;
    assign rank       = rank_reg;

endmodule

@@ hw/rtl/lfu_cache_lru_tiebreak_core.sv @@
// Key-value store with least-frequently-used replacement and a least-recent
// tie-break, built as a row of ENTRIES cells that each hold one entry (key,
// value, saturating use count and recency rank) and update themselves from a
// command broadcast along the row. One beat is worked on at a time. A get, or
// a put whose key is already present, does the parallel key compare in every
// cell and the update in the look state and then moves its result into the
// output register in the response state. A put of a new key first walks the
// row one cell per cycle to find the victim (lowest count, oldest on ties) or
// the first free cell and then writes it in the fill state before its result
// is loaded. The next request beat is taken only after the result is loaded,
// so no new request is accepted while one is in progress; a result beat that
// the receiver does not take stalls the input. The capacity register (byte
// address 0) may only be written while the block is idle; 0 behaves as 1 and
// values above ENTRIES behave as ENTRIES. A put miss with occupancy at or
// above the capacity evicts exactly one entry first.
module lfu_cache_lru_tiebreak_core #(
    parameter int ENTRIES = lfuc_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] read_value
);
    import lfuc_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam logic [RANK_W-1:0] LAST_IDX = RANK_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOK = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_FILL = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_write;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
    assign prdata    = (paddr == ADDR_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Captured request.
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] value_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    // Cell row.
    cell_cmd_t         cmd;
    logic [ENTRIES-1:0] sel;
    logic [RANK_W-1:0] ref_rank;
    cell_stat_t        stat [ENTRIES];
    logic [RANK_W-1:0] rank [ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lfuc_cell #(
            .RANK_W(RANK_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .sel        (sel[i]),
            .ref_rank   (ref_rank),
            .lookup_key (key_reg),
            .stat       (stat[i]),
            .rank       (rank[i])
        );
    end

    // Keys are unique among valid cells, so at most one cell hits and the
    // hit cell's fields can be gathered with a plain OR.
    logic [ENTRIES-1:0] hit_vec;
    logic [DATA_W-1:0]  hit_value;
    logic [RANK_W-1:0]  hit_rank;
    logic               any_hit;

    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = stat[i].hit;
            if (stat[i].hit)
            begin
                hit_value = hit_value | stat[i].value;
                hit_rank  = hit_rank | rank[i];
            end
        end
        any_hit = |hit_vec;
    end

    // Occupancy and the capacity in force.
    logic [OCC_W-1:0] occ_reg;
    logic [31:0]      eff_cap;
    logic             full;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = 32'd1;
        end
        else if (32'(cap_reg) > 32'(ENTRIES))
        begin
            eff_cap = 32'(ENTRIES);
        end
        else
        begin
            eff_cap = 32'(cap_reg);
        end
    end
    assign full = (32'(occ_reg) >= eff_cap);

    // Walk along the row: best victim and first free cell so far.
    logic [RANK_W-1:0]  scan_idx_reg;
    logic               vic_have_reg;
    logic [RANK_W-1:0]  vic_idx_reg;
    logic [COUNT_W-1:0] vic_count_reg;
    logic [RANK_W-1:0]  vic_rank_reg;
    logic               free_have_reg;
    logic [RANK_W-1:0]  free_idx_reg;
    logic               evict_reg;
    cell_stat_t         cur;
    logic [RANK_W-1:0]  cur_rank;
    logic               better;

    assign cur      = stat[scan_idx_reg];
    assign cur_rank = rank[scan_idx_reg];
    assign better   = cur.valid && (!vic_have_reg || (cur.count < vic_count_reg) ||
                      ((cur.count == vic_count_reg) && (cur_rank > vic_rank_reg)));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            scan_idx_reg  <= '0;
            vic_have_reg  <= 1'b0;
            free_have_reg <= 1'b0;
            evict_reg     <= full;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + RANK_W'(1);
            if (better)
            begin
                vic_have_reg  <= 1'b1;
                vic_idx_reg   <= scan_idx_reg;
                vic_count_reg <= cur.count;
                vic_rank_reg  <= cur_rank;
            end
            if (!cur.valid && !free_have_reg)
            begin
                free_have_reg <= 1'b1;
                free_idx_reg  <= scan_idx_reg;
            end
        end
    end

    // Command to the row.
    logic [RANK_W-1:0] fill_idx;
    assign fill_idx = evict_reg ? vic_idx_reg : free_idx_reg;

    always_comb
    begin
        cmd.kind   = CMD_NONE;
        cmd.is_put = op_reg;
        cmd.evict  = evict_reg;
        cmd.key    = key_reg;
        cmd.value  = value_reg;
        sel        = '0;
        ref_rank   = '0;
        if ((state_reg == ST_LOOK) && any_hit)
        begin
            cmd.kind = CMD_TOUCH;
            sel      = hit_vec;
            ref_rank = hit_rank;
        end
        else if (state_reg == ST_FILL)
        begin
            cmd.kind = CMD_FILL;
            ref_rank = vic_rank_reg;
            for (int i = 0; i < ENTRIES; i++)
            begin
                sel[i] = (fill_idx == RANK_W'(i));
            end
        end
    end

    // Occupancy: an eviction and an insertion cancel out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if ((state_reg == ST_FILL) && !evict_reg)
        begin
            occ_reg <= occ_reg + OCC_W'(1);
        end
    end

    // Result held until the output register is free.
    logic              res_found_reg;
    logic [DATA_W-1:0] res_value_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            res_found_reg <= any_hit;
            if (op_reg == OP_PUT)
            begin
                res_value_reg <= '0;
            end
            else if (any_hit)
            begin
                res_value_reg <= hit_value;
            end
            else
            begin
                res_value_reg <= '1;
            end
        end
    end

    logic out_load;
    assign out_load = (state_reg == ST_RESP) && (!out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if ((op_reg == OP_PUT) && !any_hit)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found      <= res_found_reg;
            read_value <= res_value_reg;
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the LFU key-value store. A driver always block takes pending
// requests from a queue filled by the stimulus process and presents them as
// beats at the falling edge. A monitor always block samples result beats at
// the rising edge and compares each one with the oldest prediction. The
// prediction is made at the moment a request beat is accepted, from a local
// model of the slots, their use counts and their recency order.
module tb_top;
    import lfuc_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        op;
        logic [31:0] k;
        logic [31:0] v;
    } request_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] data;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [31:0] read_value;

    // Local copy of the store contents.
    logic        m_valid [NSLOT];
    logic [31:0] m_key   [NSLOT];
    logic [31:0] m_val   [NSLOT];
    logic [31:0] m_count [NSLOT];
    int unsigned m_rank  [NSLOT];
    int unsigned m_used;
    logic [4:0]  m_capacity;

    request_t request_queue[$];
    answer_t  answer_queue[$];

    int  errors;
    int  beats_sent;
    int  beats_checked;
    int  hits_seen;
    int  evictions;
    int  idle_cycles;
    bit  sink_hold;
    int  sink_hold_len;

    int  drive_wait;
    int  sink_wait;

    // Set at the rising edge when a beat is taken on either channel.
    logic in_accepted;
    logic out_accepted;

    lfu_cache_lru_tiebreak_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .read_value (read_value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Move slot s to the front of the recency order.
    function automatic void make_recent(int s);
        int unsigned r;
        r = m_rank[s];
        for (int i = 0; i < NSLOT; i++)
        begin
            if (m_valid[i] && m_rank[i] < r)
                m_rank[i]++;
        end
        m_rank[s] = 0;
    endfunction

    function automatic void count_use(int s);
        if (m_count[s] < 32'h7FFF_FFFF)
            m_count[s]++;
    endfunction

    // Apply one request to the local store and return the answer it should get.
    function automatic answer_t store_access(request_t rq);
        answer_t     ans;
        int          hit;
        int          victim;
        int unsigned cap;
        int unsigned r;
        hit = -1;
        victim = -1;
        cap = (m_capacity == 0) ? 1 : ((m_capacity > NSLOT) ? NSLOT : m_capacity);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (hit < 0 && m_valid[i] && m_key[i] == rq.k)
                hit = i;
        end
        ans.hit = (hit >= 0);
        ans.data = 32'd0;
        if (rq.op == OP_GET)
        begin
            if (hit >= 0)
            begin
                count_use(hit);
                make_recent(hit);
                ans.data = m_val[hit];
            end
            else
            begin
                ans.data = 32'hFFFF_FFFF;
            end
            return ans;
        end
        if (hit >= 0)
        begin
            count_use(hit);
            m_val[hit] = rq.v;
            make_recent(hit);
            return ans;
        end
        if (m_used >= cap)
        begin
            // Lowest count wins; among equal counts the least recent goes.
            for (int i = 0; i < NSLOT; i++)
            begin
                if (m_valid[i] && (victim < 0 || m_count[i] < m_count[victim] ||
                    (m_count[i] == m_count[victim] && m_rank[i] > m_rank[victim])))
                    victim = i;
            end
            if (victim >= 0)
            begin
                r = m_rank[victim];
                m_valid[victim] = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (m_valid[i] && m_rank[i] > r)
                        m_rank[i]--;
                end
                if (m_used > 0)
                    m_used--;
                evictions++;
            end
        end
        if (victim < 0)
        begin
            for (int i = NSLOT - 1; i >= 0; i--)
            begin
                if (!m_valid[i])
                    victim = i;
            end
        end
        if (victim >= 0)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (m_valid[i])
                    m_rank[i]++;
            end
            m_valid[victim] = 1'b1;
            m_key[victim] = rq.k;
            m_val[victim] = rq.v;
            m_count[victim] = 32'd1;
            m_rank[victim] = 0;
            m_used++;
        end
        return ans;
    endfunction

    // Driver: one beat at a time from the pending queue, with a random gap
    // drawn as each beat is offered and kept before the next one is offered.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= 1'b0;
            key <= '0;
            value <= '0;
            drive_wait <= 0;
        end
        else if (in_valid && !in_accepted)
        begin
            // Beat still waiting; hold it.
        end
        else if (drive_wait > 0)
        begin
            in_valid <= 1'b0;
            drive_wait <= drive_wait - 1;
        end
        else if (request_queue.size() > 0)
        begin
            in_valid <= 1'b1;
            operation <= request_queue[0].op;
            key <= request_queue[0].k;
            value <= request_queue[0].v;
            void'(request_queue.pop_front());
            drive_wait <= $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_accepted <= 1'b0;
            out_accepted <= 1'b0;
        end
        else
        begin
            in_accepted <= in_valid && in_ready;
            out_accepted <= out_valid && out_ready;
            if (in_valid && in_ready)
            begin
                answer_queue.push_back(store_access({operation, key, value}));
                beats_sent++;
            end
        end
    end

    // Monitor: checks result beats and counts idle cycles for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (answer_queue.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: found=%0b data=%h",
                             $time, found, read_value);
                    errors++;
                end
                else
                begin
                    if (found !== answer_queue[0].hit)
                    begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, answer_queue[0].hit, found);
                        errors++;
                    end
                    if (read_value !== answer_queue[0].data)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, answer_queue[0].data, read_value);
                        errors++;
                    end
                    if (found === 1'b1)
                        hits_seen++;
                    void'(answer_queue.pop_front());
                end
                beats_checked++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver readiness: random stalls per beat, or a long hold when asked.
    always @(negedge clk or negedge rst_n)
    begin : sink_ctrl
        int stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end
        else if (sink_hold_len > 0)
        begin
            out_ready <= 1'b0;
            sink_hold_len <= sink_hold_len - 1;
        end
        else if (sink_hold)
        begin
            out_ready <= 1'b0;
            sink_hold <= 1'b0;
            sink_hold_len <= 300;
        end
        else if (sink_wait > 0)
        begin
            out_ready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end
        else if (out_accepted)
        begin
            // A beat moved at the last rising edge; draw the stall for the next one.
            stall = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                sink_wait <= stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_capacity(logic [4:0] cap);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_CAPACITY;
        pwdata <= 32'(cap);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        m_capacity = cap;
    endtask

    // Wait until every request has been sent and answered, then keep the
    // clock running for a margin before returning.
    task automatic drain;
        while (request_queue.size() > 0 || in_valid || answer_queue.size() > 0)
            @(posedge clk);
        repeat (NSLOT + 8) @(posedge clk);
    endtask

    task automatic queue_request(logic op, logic [31:0] k, logic [31:0] v);
        request_t rq;
        rq.op = op;
        rq.k = k;
        rq.v = v;
        request_queue.push_back(rq);
    endtask

    // Random phase: keys from a small pool so hits, updates and evictions are
    // frequent, with occasional fully random keys; every value is random.
    task automatic random_phase(int count, int pool);
        logic [31:0] k;
        logic [31:0] v;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                k = $urandom();
            else
                k = 32'h8000_0000 ^ 32'($urandom_range(0, pool - 1));
            v = $urandom();
            queue_request(($urandom_range(0, 2) != 0) ? OP_PUT : OP_GET, k, v);
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        hits_seen = 0;
        evictions = 0;
        idle_cycles = 0;
        sink_hold = 1'b0;
        sink_hold_len = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_used = 0;
        m_capacity = CAP_RESET;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_valid[i] = 1'b0;
            m_key[i] = '0;
            m_val[i] = '0;
            m_count[i] = '0;
            m_rank[i] = 0;
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset capacity: extreme keys and values, get
        // miss on an empty store, put miss, put hit, get hit.
        queue_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
        queue_request(OP_PUT, 32'h8000_0000, 32'h1234_5678);
        queue_request(OP_GET, 32'h8000_0000, 32'h0);
        queue_request(OP_GET, 32'h0000_0001, 32'h0);
        drain();

        // Capacity 2 with more entries already present: a put miss evicts one
        // entry, with a count tie broken by recency, and occupancy is not cut back.
        write_capacity(5'd2);
        queue_request(OP_PUT, 32'h0000_0011, 32'h11);
        queue_request(OP_GET, 32'h0000_0000, 32'h0);
        queue_request(OP_PUT, 32'h0000_0012, 32'h12);
        queue_request(OP_GET, 32'h0000_0011, 32'h0);
        queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        drain();

        // Zero acts as one: every new key pushes out the previous one.
        write_capacity(5'd0);
        queue_request(OP_PUT, 32'h0000_0021, 32'h21);
        queue_request(OP_PUT, 32'h0000_0022, 32'h22);
        queue_request(OP_GET, 32'h0000_0021, 32'h0);
        queue_request(OP_GET, 32'h0000_0022, 32'h0);
        drain();

        // Random phases across capacities, including both extremes and a
        // value above the slot count. The long receiver hold lands in the
        // first phase so that the block backs up and stalls its input.
        write_capacity(5'd31);
        sink_hold = 1'b1;
        random_phase(400, 24);
        write_capacity(5'd1);
        random_phase(250, 4);
        write_capacity(5'd16);
        random_phase(400, 20);
        write_capacity(5'd5);
        random_phase(350, 10);
        write_capacity(5'd17);
        random_phase(300, 40);
        write_capacity(5'd9);
        random_phase(300, 14);

        $display("Sent %0d requests and checked %0d results: %0d hits, %0d evictions.",
                 beats_sent, beats_checked, hits_seen, evictions);
        $display("Capacities covered: 0, 1, 2, 5, 9, 16, 17 and 31.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
